// ===== sv/interval_selection_with_gap_defines.svh =====
// Assertion macros used by the interval selection datapath.
`ifndef INTERVAL_SELECTION_WITH_GAP_DEFINES_SVH
`define INTERVAL_SELECTION_WITH_GAP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("interval selection check failed");

// Next-cycle implication, checked outside reset.
`define ISG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("interval selection check failed");

`endif

// ===== sv/isg_pkg.sv =====
// Types and constants shared by the interval selection modules.
package isg_pkg;
   localparam int HourW  = 5;
   localparam int MinW   = 6;
   localparam int DurW   = 11;
   localparam int StartW = 11;
   localparam int EndW   = 12;
   localparam int ThrW   = 13;
   localparam int GapW   = 10;
   localparam int CountW = 9;

   localparam logic [GapW-1:0] GapReset       = 10'd10;
   localparam logic [6:0]      MinutesPerHour = 7'd60;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic pass_start;
      logic issue;
      logic decide;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_addr;
      logic found;
      logic out_free;
   } status_type;
endpackage

// ===== sv/isg_ctrl.sv =====
// Controller state machine: loading, selection passes and result hand-off.
module isg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_item,
   output logic               req_ready,
   input  isg_pkg::status_type status,
   output isg_pkg::cmd_type    cmd
);
   import isg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_item) begin
                  cmd.pass_start = 1'b1;
                  state_in       = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // Another interval was picked, so run one more pass above the new threshold.
            if (status.found) begin
               cmd.decide     = 1'b1;
               cmd.pass_start = 1'b1;
               state_in       = ST_ISSUE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end
endmodule

// ===== sv/isg_dpath.sv =====
// Datapath: interval store, selection scan, gap register and result register.
`include "interval_selection_with_gap_defines.svh"
module isg_dpath #(
   parameter int MAX_INTERVALS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [isg_pkg::HourW-1:0] req_start_hour,
   input  logic [isg_pkg::MinW-1:0]  req_start_minute,
   input  logic [isg_pkg::DurW-1:0]  req_duration,
   input  logic                      csr_we,
   input  logic [isg_pkg::GapW-1:0]  csr_wdata,
   input  isg_pkg::cmd_type           cmd,
   output isg_pkg::status_type        status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [isg_pkg::CountW-1:0] rsp_chosen_count,
   output logic                      rsp_overflow
);
   import isg_pkg::*;

   localparam int AW  = $clog2(MAX_INTERVALS);
   localparam int LCW = $clog2(MAX_INTERVALS + 1);
   localparam int EW  = StartW + EndW;

   logic [EW-1:0]     mem [MAX_INTERVALS];
   logic [EW-1:0]     rd_data_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic              rd_valid_ff;
   logic [AW-1:0]     scan_addr_ff;
   logic [LCW-1:0]    load_cnt_ff;
   logic              ovf_ff;
   logic [GapW-1:0]   gap_ff;
   logic [ThrW-1:0]   thresh_ff;
   logic [LCW-1:0]    count_ff;
   logic              best_found_ff;
   logic [EndW-1:0]   best_end_ff;
   logic [AW-1:0]     best_addr_ff;
   logic [EndW-1:0]   last_end_ff;
   logic [AW-1:0]     last_addr_ff;
   logic              rsp_valid_ff;
   logic [CountW-1:0] rsp_count_ff;
   logic              rsp_ovf_ff;

   logic [StartW-1:0] start_w;
   logic [EndW-1:0]   end_w;
   logic              full;
   logic [StartW-1:0] rd_start;
   logic [EndW-1:0]   rd_end;
   logic              later;
   logic              better;

   assign start_w = StartW'(req_start_hour) * StartW'(MinutesPerHour)
                  + StartW'(req_start_minute);
   assign end_w   = EndW'(start_w) + EndW'(req_duration);
   assign full    = (load_cnt_ff == LCW'(MAX_INTERVALS));

   assign rd_start = rd_data_ff[EW-1:EndW];
   assign rd_end   = rd_data_ff[EndW-1:0];
   // An interval must come after the last pick in end order, ties broken by load order.
   // Only zero-length intervals at a zero gap can otherwise be picked twice.
   assign later    = (count_ff == '0) || (rd_end != last_end_ff)
                  || (rd_addr_ff > last_addr_ff);
   // Each pass picks the eligible interval with the earliest end.
   assign better   = rd_valid_ff && (ThrW'(rd_start) >= thresh_ff) && later
                  && (!best_found_ff || rd_end < best_end_ff);

   assign status.last_addr = (LCW'(scan_addr_ff) == load_cnt_ff - LCW'(1));
   assign status.found     = best_found_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_count = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         mem[load_cnt_ff[AW-1:0]] <= {start_w, end_w};
      end
      rd_data_ff <= mem[scan_addr_ff];
      rd_addr_ff <= scan_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         scan_addr_ff  <= '0;
         load_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
         gap_ff        <= GapReset;
         thresh_ff     <= '0;
         count_ff      <= '0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.issue;
         if (csr_we) begin
            gap_ff <= csr_wdata;
         end
         if (cmd.pass_start) begin
            scan_addr_ff <= '0;
         end else if (cmd.issue) begin
            scan_addr_ff <= scan_addr_ff + AW'(1);
         end
         if (cmd.out_load) begin
            load_cnt_ff <= '0;
            ovf_ff      <= 1'b0;
         end else if (cmd.load) begin
            if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               load_cnt_ff <= load_cnt_ff + LCW'(1);
            end
         end
         if (cmd.pass_start) begin
            best_found_ff <= 1'b0;
         end else if (better) begin
            best_found_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            thresh_ff <= '0;
            count_ff  <= '0;
         end else if (cmd.decide) begin
            thresh_ff <= ThrW'(best_end_ff) + ThrW'(gap_ff);
            count_ff  <= count_ff + LCW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (better) begin
         best_end_ff  <= rd_end;
         best_addr_ff <= rd_addr_ff;
      end
      if (cmd.decide) begin
         last_end_ff  <= best_end_ff;
         last_addr_ff <= best_addr_ff;
      end
      if (cmd.out_load) begin
         rsp_count_ff <= CountW'(count_ff);
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   `ISG_ASSERT_IMPL(a_count_le_loaded, clock, reset, 1'b1, count_ff <= load_cnt_ff)
   `ISG_ASSERT_IMPL(a_loaded_le_cap, clock, reset, 1'b1, load_cnt_ff <= LCW'(MAX_INTERVALS))
   `ISG_ASSERT_IMPL(a_scan_in_range, clock, reset, cmd.issue, LCW'(scan_addr_ff) < load_cnt_ff)
   `ISG_ASSERT_NEXT(a_result_shown, clock, reset, cmd.out_load, rsp_valid_ff)
endmodule

// ===== sv/interval_selection_with_gap.sv =====
// Top level of the interval selection block: controller plus datapath.
// Intervals load at one item per cycle into a store of MAX_INTERVALS entries with one
// write and one read port; loads beyond capacity are dropped and reported in the overflow
// bit. The item marked last starts the selection, which makes k+1 passes over the n stored
// intervals through the one read port of the store (k is the chosen count); once any
// earlier result has been taken, the count moves into the result register. No new item is
// taken during selection, while a result still waiting on the output does not hold up
// loading.
module interval_selection_with_gap #(
   parameter int MAX_INTERVALS = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [isg_pkg::HourW-1:0]  req_start_hour,
   input  logic [isg_pkg::MinW-1:0]   req_start_minute,
   input  logic [isg_pkg::DurW-1:0]   req_duration,
   input  logic                       req_last_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [isg_pkg::CountW-1:0] rsp_chosen_count,
   output logic                       rsp_overflow,
   input  logic                       csr_we,
   input  logic [isg_pkg::GapW-1:0]   csr_wdata
);
   import isg_pkg::*;

   cmd_type    cmd;
   status_type status;

   isg_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   isg_dpath #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_start_hour   (req_start_hour),
      .req_start_minute (req_start_minute),
      .req_duration     (req_duration),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chosen_count (rsp_chosen_count),
      .rsp_overflow     (rsp_overflow)
   );
endmodule
